// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge once reset is released
`define TPF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define TPF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/tpf_pkg.sv -----
package tpf_pkg;

  localparam int TileBytes = 16384;
  localparam int TileWords = TileBytes / 2;
  localparam int TileWordW = $clog2(TileWords);
  localparam int TileAddrW = $clog2(TileBytes);
  // background and object palettes share one store, 64 bytes each
  localparam int PalBytes  = 128;
  localparam int PalWords  = PalBytes / 2;
  localparam int PalWordW  = $clog2(PalWords);
  localparam int PalAddrW  = $clog2(PalBytes);

  localparam int AttrBank  = 3;
  localparam int AttrXFlip = 5;
  localparam int AttrYFlip = 6;

  typedef enum logic [2:0] {
    CMD_WR_TILE    = 3'd0,
    CMD_WR_BG_PAL  = 3'd1,
    CMD_WR_OBJ_PAL = 3'd2,
    CMD_BG_PIXEL   = 3'd3,
    CMD_OBJ_PIXEL  = 3'd4
  } cmd_t;

  typedef struct packed {
    logic                 tile_we;
    logic                 pal_we;
    logic [TileAddrW-1:0] tile_addr;
    logic [PalAddrW-1:0]  pal_addr;
    logic [7:0]           data;
  } wr_t;

  typedef struct packed {
    logic                 valid;
    logic                 is_obj;
    logic                 force_zero;
    logic [2:0]           bit_sel;
    logic [2:0]           pal;
    logic [TileWordW-1:0] word;
  } req_t;

  // c * 255 / 31, truncated
  localparam logic [7:0] Expand5 [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

  function automatic logic [31:0] widen_rgb555(input logic [14:0] c);
    widen_rgb555 = {8'hff, Expand5[c[4:0]], Expand5[c[9:5]], Expand5[c[14:10]]};
  endfunction

endpackage

// ----- sv/tpf_ram.sv -----
module tpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents when the same entry is written
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/tpf_decode.sv -----
module tpf_decode (
  input  logic          [2:0]  cmd,
  input  logic          [55:0] fields,
  input  logic                 unsigned_tile_mode,
  output tpf_pkg::wr_t         wr,
  output tpf_pkg::req_t        req
);

  logic [13:0] write_address;
  logic [7:0]  write_data;
  logic [7:0]  tile_number;
  logic [7:0]  attrs;
  logic [7:0]  pixel_x;
  logic [7:0]  pixel_y;
  logic        tall_object;
  logic        cell_visible;

  logic [2:0]  x_flip;
  logic [2:0]  y_bg;
  logic [8:0]  bg_base;
  logic        obj_in_range;
  logic [3:0]  y_obj;
  logic [7:0]  obj_tile;

  assign write_address = fields[13:0];
  assign write_data    = fields[21:14];
  assign tile_number   = fields[29:22];
  assign attrs         = fields[37:30];
  assign pixel_x       = fields[45:38];
  assign pixel_y       = fields[53:46];
  assign tall_object   = fields[54];
  assign cell_visible  = fields[55];

  assign x_flip = pixel_x[2:0] ^ {3{attrs[tpf_pkg::AttrXFlip]}};
  assign y_bg   = pixel_y[2:0] ^ {3{attrs[tpf_pkg::AttrYFlip]}};

  // signed mode: 0x1000 + sext(tile) * 16, in units of 16 bytes
  assign bg_base = unsigned_tile_mode ? {1'b0, tile_number} : {~tile_number[7], tile_number};

  assign obj_in_range = (pixel_x[7:3] == 5'd0) &&
                        (tall_object ? (pixel_y[7:4] == 4'd0) : (pixel_y[7:3] == 5'd0));
  assign y_obj = tall_object ? (pixel_y[3:0] ^ {4{attrs[tpf_pkg::AttrYFlip]}})
                             : {1'b0, pixel_y[2:0] ^ {3{attrs[tpf_pkg::AttrYFlip]}}};
  // lower half of a tall object uses the odd tile
  assign obj_tile = tall_object ? {tile_number[7:1], y_obj[3]} : tile_number;

  always_comb begin
    wr            = '0;
    req           = '0;
    wr.tile_addr  = write_address;
    wr.data       = write_data;
    wr.pal_addr   = {tpf_pkg::cmd_t'(cmd) == tpf_pkg::CMD_WR_OBJ_PAL, write_address[5:0]};
    req.pal       = attrs[2:0];
    req.bit_sel   = ~x_flip;
    case (tpf_pkg::cmd_t'(cmd))
      tpf_pkg::CMD_WR_TILE: begin
        wr.tile_we = 1'b1;
      end
      tpf_pkg::CMD_WR_BG_PAL, tpf_pkg::CMD_WR_OBJ_PAL: begin
        wr.pal_we = (write_address[13:6] == 8'd0);
      end
      tpf_pkg::CMD_BG_PIXEL: begin
        req.valid      = 1'b1;
        req.force_zero = !cell_visible;
        req.word       = {attrs[tpf_pkg::AttrBank], bg_base, y_bg};
      end
      tpf_pkg::CMD_OBJ_PIXEL: begin
        req.valid      = 1'b1;
        req.is_obj     = 1'b1;
        req.force_zero = !obj_in_range;
        req.word       = {attrs[tpf_pkg::AttrBank], 1'b0, obj_tile, y_obj[2:0]};
      end
      default: begin
        req.valid = 1'b0;
      end
    endcase
  end

endmodule

// ----- sv/tile_pixel_fetch_rgb555.sv -----
// Tile pixel fetch with RGB555 palettes and ARGB8888 output.
// in_*: one request per handshake; in_tuser carries the command (write tile byte,
// write background or object palette byte, background pixel, object pixel).
// Write requests update the stores and give no result; pixel requests give one
// result word on out_*. cfg_wen/cfg_wdata set the tile numbering mode while idle.
// Tile data sits in an even-byte and an odd-byte memory so both bit planes of a row
// come out in one read; the palettes share one even/odd pair the same way.
// A pixel request goes through the tile read at acceptance, the palette read and
// colour expansion into the output register. Throughput: one request per cycle
// while in_tready is high; each request makes at most one access to the tile memory
// port and one to the palette memory port.
// Reset (rst_n low at a clock edge) empties the pipeline and sets unsigned tile mode;
// the memories keep their contents and read as garbage until written.
// When the receiver stalls, the result holds in the output register and the stages
// behind it keep filling their empty slots before in_tready drops.
module tile_pixel_fetch_rgb555 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // write_address[13:0], write_data[21:14], tile_number[29:22], tile_attributes[37:30],
  // pixel_x[45:38], pixel_y[53:46], tall_object[54], cell_visible[55]
  input  logic [55:0] in_tdata,
  // cmd[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // pixel_argb[31:0]
  output logic [31:0] out_tdata,
  input  logic        cfg_wen,
  input  logic        cfg_wdata
);

  `include "assert_macros.svh"

  logic                  unsigned_tile_mode_r;
  tpf_pkg::wr_t          in_wr;
  tpf_pkg::req_t         in_req;
  logic                  in_accept;

  logic                  s1_valid_r;
  tpf_pkg::req_t         s1_r;
  logic                  s2_valid_r;
  logic                  s2_zero_r;
  logic                  out_valid_r;
  logic [31:0]           out_data_r;

  logic                  en_out;
  logic                  en_s2;
  logic                  en_s1;

  logic [7:0]            tile_even_q;
  logic [7:0]            tile_odd_q;
  logic [7:0]            pal_even_q;
  logic [7:0]            pal_odd_q;
  logic [1:0]            s1_idx;
  logic                  s1_zero;
  logic [tpf_pkg::PalWordW-1:0] pal_raddr;
  logic [14:0]           s2_colour;

  tpf_decode u_decode (
    .cmd                (in_tuser),
    .fields             (in_tdata),
    .unsigned_tile_mode (unsigned_tile_mode_r),
    .wr                 (in_wr),
    .req                (in_req)
  );

  // each stage moves when the one ahead of it moves or is empty
  assign en_out    = !out_valid_r || out_tready;
  assign en_s2     = en_out || !s2_valid_r;
  assign en_s1     = en_s2 || !s1_valid_r;
  assign in_tready = en_s1;
  assign in_accept = in_tvalid && in_tready;

  tpf_ram #(.WIDTH(8), .DEPTH(tpf_pkg::TileWords)) u_tile_even (
    .clk   (clk),
    .we    (in_accept && in_wr.tile_we && !in_wr.tile_addr[0]),
    .waddr (in_wr.tile_addr[tpf_pkg::TileAddrW-1:1]),
    .wdata (in_wr.data),
    .re    (en_s1),
    .raddr (in_req.word),
    .rdata (tile_even_q)
  );

  tpf_ram #(.WIDTH(8), .DEPTH(tpf_pkg::TileWords)) u_tile_odd (
    .clk   (clk),
    .we    (in_accept && in_wr.tile_we && in_wr.tile_addr[0]),
    .waddr (in_wr.tile_addr[tpf_pkg::TileAddrW-1:1]),
    .wdata (in_wr.data),
    .re    (en_s1),
    .raddr (in_req.word),
    .rdata (tile_odd_q)
  );

  // stage 1: pick the colour index out of the two bit planes
  assign s1_idx    = {tile_odd_q[s1_r.bit_sel], tile_even_q[s1_r.bit_sel]};
  assign s1_zero   = s1_r.force_zero || (s1_r.is_obj && (s1_idx == 2'd0));
  assign pal_raddr = {s1_r.is_obj, s1_r.pal, s1_idx};

  tpf_ram #(.WIDTH(8), .DEPTH(tpf_pkg::PalWords)) u_pal_even (
    .clk   (clk),
    .we    (in_accept && in_wr.pal_we && !in_wr.pal_addr[0]),
    .waddr (in_wr.pal_addr[tpf_pkg::PalAddrW-1:1]),
    .wdata (in_wr.data),
    .re    (en_s2),
    .raddr (pal_raddr),
    .rdata (pal_even_q)
  );

  tpf_ram #(.WIDTH(8), .DEPTH(tpf_pkg::PalWords)) u_pal_odd (
    .clk   (clk),
    .we    (in_accept && in_wr.pal_we && in_wr.pal_addr[0]),
    .waddr (in_wr.pal_addr[tpf_pkg::PalAddrW-1:1]),
    .wdata (in_wr.data),
    .re    (en_s2),
    .raddr (pal_raddr),
    .rdata (pal_odd_q)
  );

  // stage 2: little-endian RGB555 word
  assign s2_colour = {pal_odd_q[6:0], pal_even_q};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unsigned_tile_mode_r <= 1'b1;
      s1_valid_r           <= 1'b0;
      s2_valid_r           <= 1'b0;
      out_valid_r          <= 1'b0;
    end else begin
      if (cfg_wen) begin
        unsigned_tile_mode_r <= cfg_wdata;
      end
      if (en_s1) begin
        s1_valid_r <= in_accept && in_req.valid;
      end
      if (en_s2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (en_out) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_s1) begin
      s1_r <= in_req;
    end
    if (en_s2) begin
      s2_zero_r <= s1_zero;
    end
    if (en_out) begin
      out_data_r <= s2_zero_r ? 32'd0 : tpf_pkg::widen_rgb555(s2_colour);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `TPF_ASSERT(a_pixel_enters_pipe, in_accept && in_req.valid |=> s1_valid_r, "pixel request lost at stage 1")
  `TPF_ASSERT(a_write_no_result, in_accept && !in_req.valid |=> !s1_valid_r, "write request produced a pixel slot")
  `TPF_ASSERT(a_full_pipe_stalls, out_valid_r && !out_tready && s2_valid_r && s1_valid_r |-> !in_tready, "request taken into a full pipeline")
  `TPF_ASSERT(a_alpha_opaque, out_valid_r && (out_tdata != 32'd0) |-> out_tdata[31:24] == 8'hff, "visible pixel without full alpha")
  `TPF_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid_r && !s1_valid_r && !s2_valid_r, "pipeline not empty after reset")

endmodule

// ----- tb/tb_tile_pixel_fetch_rgb555.sv -----
module tb_tile_pixel_fetch_rgb555;
  import tpf_pkg::*;

  localparam logic [2:0] CmdSpareFirst = 3'd5;
  localparam logic [2:0] CmdSpareLast  = 3'd7;
  localparam int PalBytesEach = 64;
  localparam int CycleLimit   = 300000;
  localparam int RandomPerPhase = 70;

  typedef struct {
    logic [2:0]        cmd;
    logic [13:0]       waddr;
    logic [7:0]        wdata;
    logic [7:0]        tile;
    logic [7:0]        attrs;
    logic signed [7:0] px;
    logic signed [7:0] py;
    logic              tall;
    logic              vis;
  } pix_req_t;

  typedef struct {
    logic [13:0] row_addr;
    logic [2:0]  bit_pos;
    logic        in_tile;
  } tile_loc_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        cfg_wen;
  logic        cfg_wdata;

  tile_pixel_fetch_rgb555 i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  // shadow of the block's stores, updated in acceptance order
  bit [7:0] tile_shadow    [TileBytes];
  bit [7:0] bg_pal_shadow  [PalBytesEach];
  bit [7:0] obj_pal_shadow [PalBytesEach];
  logic     tile_mode_model;

  // which entries the stimulus has written so far
  bit       tile_filled    [TileBytes];
  bit       bg_pal_filled  [PalBytesEach];
  bit       obj_pal_filled [PalBytesEach];
  logic     gen_mode;

  pix_req_t    req_queue[$];
  logic [31:0] argb_expected[$];
  pix_req_t    cur_req;
  bit          req_taken;
  bit          calm;
  logic [7:0]  tile_pool [8];
  logic [31:0] want;
  int          fail_count;
  int          cycle_count = 0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [7:0] scale5to8(input logic [4:0] v);
    int p;
    p = int'(v) * 255 / 31;
    return p[7:0];
  endfunction

  // tile row address and bit column that a pixel request reads
  function automatic tile_loc_t locate_texel(input pix_req_t r, input logic unsigned_mode);
    tile_loc_t loc;
    int x, y, h, tile, base, a;
    if (r.cmd == CMD_BG_PIXEL) begin
      x = int'(r.px[2:0]);
      y = int'(r.py[2:0]);
      h = 8;
      loc.in_tile = 1'b1;
    end else begin
      x = int'(r.px);
      y = int'(r.py);
      h = r.tall ? 16 : 8;
      loc.in_tile = (x >= 0 && x < 8 && y >= 0 && y < h);
      if (!loc.in_tile) begin
        x = 0;
        y = 0;
      end
    end
    if (r.attrs[AttrXFlip]) x = 7 - x;
    if (r.attrs[AttrYFlip]) y = h - 1 - y;
    tile = int'(r.tile);
    if (r.cmd == CMD_BG_PIXEL) begin
      base = unsigned_mode ? tile * 16 : 4096 + int'($signed(r.tile)) * 16;
    end else begin
      // tall objects: even tile on top, next tile below
      if (r.tall) tile = (tile & 254) + y / 8;
      base = (tile & 255) * 16;
    end
    a = (r.attrs[AttrBank] ? 8192 : 0) + base + (y % 8) * 2;
    loc.row_addr = a[13:0];
    loc.bit_pos = 3'(7 - x);
    return loc;
  endfunction

  function automatic logic [31:0] predict_argb(input pix_req_t r);
    tile_loc_t   loc;
    logic [13:0] nxt;
    logic [7:0]  lo, hi;
    logic [1:0]  idx;
    logic [5:0]  off;
    logic [15:0] c;
    logic        is_obj;
    is_obj = (r.cmd == CMD_OBJ_PIXEL);
    loc = locate_texel(r, tile_mode_model);
    if (!is_obj && !r.vis) return 32'h0;
    if (is_obj && !loc.in_tile) return 32'h0;
    nxt = loc.row_addr + 14'd1;
    lo = tile_shadow[loc.row_addr];
    hi = tile_shadow[nxt];
    idx = {hi[loc.bit_pos], lo[loc.bit_pos]};
    // colour 0 is transparent for objects
    if (is_obj && idx == 2'd0) return 32'h0;
    off = {r.attrs[2:0], idx, 1'b0};
    if (is_obj) c = {obj_pal_shadow[off + 6'd1], obj_pal_shadow[off]};
    else c = {bg_pal_shadow[off + 6'd1], bg_pal_shadow[off]};
    return {8'hff, scale5to8(c[4:0]), scale5to8(c[9:5]), scale5to8(c[14:10])};
  endfunction

  function automatic pix_req_t noise_req();
    pix_req_t r;
    r.cmd   = CMD_WR_TILE;
    r.waddr = 14'($urandom);
    r.wdata = 8'($urandom);
    r.tile  = 8'($urandom);
    r.attrs = 8'($urandom);
    r.px    = 8'($urandom);
    r.py    = 8'($urandom);
    r.tall  = 1'($urandom);
    r.vis   = 1'($urandom);
    return r;
  endfunction

  function automatic pix_req_t pixel_req(input logic [2:0] cmd, input logic [7:0] tile,
                                         input logic [7:0] attrs, input int px, input int py,
                                         input logic tall, input logic vis);
    pix_req_t r;
    r = noise_req();
    r.cmd   = cmd;
    r.tile  = tile;
    r.attrs = attrs;
    r.px    = 8'(px);
    r.py    = 8'(py);
    r.tall  = tall;
    r.vis   = vis;
    return r;
  endfunction

  task automatic push_write(input logic [2:0] cmd, input logic [13:0] addr,
                            input logic [7:0] data);
    pix_req_t r;
    r = noise_req();
    r.cmd   = cmd;
    r.waddr = addr;
    r.wdata = data;
    case (cmd)
      CMD_WR_TILE:    tile_filled[addr] = 1'b1;
      CMD_WR_BG_PAL:  if (addr < PalBytesEach) bg_pal_filled[addr[5:0]] = 1'b1;
      CMD_WR_OBJ_PAL: if (addr < PalBytesEach) obj_pal_filled[addr[5:0]] = 1'b1;
      default: ;
    endcase
    req_queue.push_back(r);
  endtask

  // a pixel request, preceded by writes of any entry it would read that is still unwritten
  task automatic add_pixel(input pix_req_t r);
    tile_loc_t   loc;
    logic [13:0] a;
    logic [5:0]  p;
    loc = locate_texel(r, gen_mode);
    if (r.cmd == CMD_BG_PIXEL || loc.in_tile) begin
      for (int k = 0; k < 2; k++) begin
        a = loc.row_addr + 14'(k);
        if (!tile_filled[a]) push_write(CMD_WR_TILE, a, 8'($urandom));
      end
      for (int j = 0; j < 8; j++) begin
        p = {r.attrs[2:0], 3'(j)};
        if (r.cmd == CMD_BG_PIXEL) begin
          if (!bg_pal_filled[p]) push_write(CMD_WR_BG_PAL, 14'(p), 8'($urandom));
        end else begin
          if (!obj_pal_filled[p]) push_write(CMD_WR_OBJ_PAL, 14'(p), 8'($urandom));
        end
      end
    end
    req_queue.push_back(r);
  endtask

  task automatic drain_results();
    while (req_queue.size() != 0 || in_tvalid || argb_expected.size() != 0) @(posedge clk);
  endtask

  task automatic set_tile_mode(input logic v);
    drain_results();
    // writes leave no result behind, so give the pipeline time to settle
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wen <= 1'b0;
    gen_mode = v;
  endtask

  task automatic run_random(input int n);
    pix_req_t r;
    int k, pick;
    k = 0;
    while (k < n) begin
      pick = int'($urandom_range(99));
      r = noise_req();
      if (pick < 70) begin
        r.cmd = (pick < 35) ? CMD_BG_PIXEL : CMD_OBJ_PIXEL;
        if ($urandom_range(3) != 0) r.tile = tile_pool[3'($urandom_range(7))];
        if (r.cmd == CMD_BG_PIXEL) begin
          r.vis = ($urandom_range(4) != 0);
        end else if ($urandom_range(4) != 0) begin
          r.px = 8'($urandom_range(7));
          r.py = 8'($urandom_range(r.tall ? 15 : 7));
        end
        add_pixel(r);
        k++;
      end else if (pick < 85) begin
        push_write(CMD_WR_TILE, 14'($urandom), 8'($urandom));
        k++;
      end else if (pick < 95) begin
        push_write((pick < 90) ? CMD_WR_BG_PAL : CMD_WR_OBJ_PAL,
                   14'($urandom_range(1) ? $urandom_range(PalBytesEach - 1)
                                         : $urandom_range(16383)),
                   8'($urandom));
        k++;
      end else begin
        r.cmd = 3'($urandom_range(CmdSpareLast, CmdSpareFirst));
        req_queue.push_back(r);
      end
    end
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || req_taken) begin
      req_taken = 1'b0;
      if (req_queue.size() != 0 && (calm || $urandom_range(99) >= 15)) begin
        cur_req = req_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= cur_req.cmd;
        in_tdata  <= {cur_req.vis, cur_req.tall, cur_req.py, cur_req.px, cur_req.attrs,
                      cur_req.tile, cur_req.wdata, cur_req.waddr};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= calm || $urandom_range(99) >= 15;
  end

  // acceptance, prediction and result check
  always @(posedge clk) begin
    if (!rst_n) begin
      tile_mode_model = 1'b1;
    end else begin
      if (cfg_wen) tile_mode_model = cfg_wdata;
      if (in_tvalid && in_tready) begin
        req_taken = 1'b1;
        case (cur_req.cmd)
          CMD_WR_TILE: tile_shadow[cur_req.waddr] = cur_req.wdata;
          CMD_WR_BG_PAL:
            if (cur_req.waddr < PalBytesEach) bg_pal_shadow[cur_req.waddr[5:0]] = cur_req.wdata;
          CMD_WR_OBJ_PAL:
            if (cur_req.waddr < PalBytesEach) obj_pal_shadow[cur_req.waddr[5:0]] = cur_req.wdata;
          CMD_BG_PIXEL, CMD_OBJ_PIXEL: argb_expected.push_back(predict_argb(cur_req));
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (argb_expected.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual pixel_argb %h",
                   $time, out_tdata);
        end else begin
          want = argb_expected.pop_front();
          if (out_tdata !== want) begin
            fail_count++;
            $display("%0t: pixel_argb expected %h actual %h", $time, want, out_tdata);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    cfg_wen    = 1'b0;
    cfg_wdata  = 1'b0;
    calm       = 1'b0;
    gen_mode   = 1'b1;
    fail_count = 0;
    tile_pool[0] = 8'h00;
    tile_pool[1] = 8'h7f;
    tile_pool[2] = 8'h80;
    tile_pool[3] = 8'hff;
    for (int i = 4; i < 8; i++) tile_pool[i] = 8'($urandom);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, ignored palette writes, flips, clipping, tall objects, spare codes
    push_write(CMD_WR_TILE, 14'h3fff, 8'hff);
    push_write(CMD_WR_TILE, 14'h0000, 8'h00);
    push_write(CMD_WR_TILE, 14'h0001, 8'h00);
    push_write(CMD_WR_BG_PAL, 14'd63, 8'hff);
    push_write(CMD_WR_OBJ_PAL, 14'd64, 8'h5a);
    push_write(CMD_WR_BG_PAL, 14'h3fff, 8'ha5);
    add_pixel(pixel_req(CMD_BG_PIXEL, 8'h00, 8'h00, 0, 0, 1'b0, 1'b0));
    add_pixel(pixel_req(CMD_BG_PIXEL, 8'h00, 8'h00, 0, 0, 1'b0, 1'b1));
    add_pixel(pixel_req(CMD_BG_PIXEL, 8'hff, 8'hff, -1, 127, 1'b1, 1'b1));
    add_pixel(pixel_req(CMD_BG_PIXEL, 8'h80, 8'h60, -128, -128, 1'b0, 1'b1));
    add_pixel(pixel_req(CMD_OBJ_PIXEL, 8'h00, 8'h00, 7, 0, 1'b0, 1'b1));
    add_pixel(pixel_req(CMD_OBJ_PIXEL, 8'h00, 8'h00, -128, 0, 1'b0, 1'b1));
    add_pixel(pixel_req(CMD_OBJ_PIXEL, 8'h00, 8'h00, 8, 0, 1'b0, 1'b1));
    add_pixel(pixel_req(CMD_OBJ_PIXEL, 8'h00, 8'h00, 0, 8, 1'b0, 1'b1));
    add_pixel(pixel_req(CMD_OBJ_PIXEL, 8'h81, 8'h41, 3, 15, 1'b1, 1'b1));
    add_pixel(pixel_req(CMD_OBJ_PIXEL, 8'h81, 8'h00, 3, 16, 1'b1, 1'b1));
    add_pixel(pixel_req(CMD_OBJ_PIXEL, 8'h10, 8'h00, 2, -1, 1'b0, 1'b1));
    add_pixel(pixel_req(CMD_OBJ_PIXEL, 8'hff, 8'hff, 0, 127, 1'b1, 1'b1));
    add_pixel(pixel_req(CMD_OBJ_PIXEL, 8'h03, 8'h2a, 0, 9, 1'b1, 1'b1));
    for (int c = CmdSpareFirst; c <= CmdSpareLast; c++) begin
      cur_req = noise_req();
      cur_req.cmd = 3'(c);
      req_queue.push_back(cur_req);
    end

    set_tile_mode(1'b0);
    run_random(RandomPerPhase);
    set_tile_mode(1'b1);
    calm = 1'b1;
    run_random(RandomPerPhase);
    set_tile_mode(1'b0);
    calm = 1'b0;
    run_random(RandomPerPhase);

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- tile_pixel_fetch_rgb555.f -----
+incdir+sv
sv/tpf_pkg.sv
sv/tpf_ram.sv
sv/tpf_decode.sv
sv/tile_pixel_fetch_rgb555.sv
tb/tb_tile_pixel_fetch_rgb555.sv
